[sv/rrc_pkg.sv]
`default_nettype none
package rrc_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int TIME_W    = 32;
    localparam int TONE_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TALK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_ENABLE  = 3'd5;

    localparam logic [CFG_W-1:0]  RST_TAIL_TIMEOUT = 24'd10000;
    localparam logic [CFG_W-1:0]  RST_ID_PERIOD    = 24'd600000;
    localparam logic [CFG_W-1:0]  RST_MAX_TALK     = 24'd300000;
    localparam logic [TONE_W-1:0] RST_MIN_TONE     = 16'd200;
    localparam logic [CFG_W-1:0]  RST_TONE_TIMEOUT = 24'd10000;

    localparam logic [2:0] SND_NONE     = 3'd0;
    localparam logic [2:0] SND_CANCEL   = 3'd1;
    localparam logic [2:0] SND_STARTUP  = 3'd2;
    localparam logic [2:0] SND_IDENT    = 3'd3;
    localparam logic [2:0] SND_COURTESY = 3'd4;
    localparam logic [2:0] SND_SIGNOFF  = 3'd5;
    localparam logic [2:0] SND_LONG     = 3'd6;
    localparam logic [2:0] SND_INACTIVE = 3'd7;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_TONEWAIT = 5'b00010,
        MODE_TONEMEAS = 5'b00100,
        MODE_TALK     = 5'b01000,
        MODE_TAIL     = 5'b10000
    } t_mode;

    typedef struct packed {
        logic              tx_on;
        logic [2:0]        sound_code;
        logic              id_before_sound;
        logic              announce_request;
        logic              session_end;
        logic [TIME_W-1:0] session_ms;
    } t_result;

endpackage
`default_nettype wire

[sv/rrc_if.sv]
`default_nettype none
interface rrc_in_if;
    logic valid;
    logic ready;
    logic squelch_open;
    logic tone_present;

    modport source (output valid, output squelch_open, output tone_present, input ready);
    modport sink (input valid, input squelch_open, input tone_present, output ready);
endinterface

interface rrc_out_if;
    logic        valid;
    logic        ready;
    logic        tx_on;
    logic [2:0]  sound_code;
    logic        id_before_sound;
    logic        announce_request;
    logic        session_end;
    logic [31:0] session_ms;

    modport source (
        output valid, output tx_on, output sound_code, output id_before_sound,
        output announce_request, output session_end, output session_ms, input ready
    );
    modport sink (
        input valid, input tx_on, input sound_code, input id_before_sound,
        input announce_request, input session_end, input session_ms, output ready
    );
endinterface
`default_nettype wire

[sv/radio_repeater_controller.sv]
`default_nettype none
// A result is registered in r_out, or in the skid entry r_skd while r_out waits.
// Throughput: one item per cycle while r_skd is empty; state updates in one pass.
// A two-entry result buffer lets one item enter while a result waits downstream.
// Reset is synchronous and active low: mode goes to idle, all timers clear and the
// configuration registers return to their default values.
module radio_repeater_controller (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rrc_pkg::CFG_W-1:0]         i_cfg_data,
    rrc_in_if.sink                                 i_in,
    rrc_out_if.source                              o_out
);
    import rrc_pkg::*;

    logic [CFG_W-1:0]  r_tail_to, r_id_period, r_max_talk, r_tone_to;
    logic [TONE_W-1:0] r_min_tone;
    logic              r_tone_en;

    t_mode             r_mode, n_mode;
    logic [TIME_W-1:0] r_now, r_last, n_last, r_open, n_open, r_phase, n_phase;
    logic              r_prev_sq, r_prev_tone;

    t_result           r_out, r_skd, n_res;
    logic              r_out_v, r_skd_v;

    logic              accept, pop, sq, tone, changed, timed;
    logic [TIME_W-1:0] now1, elapsed, limit, diff_ident, diff_open;
    logic [CFG_W-1:0]  lim_sel;
    logic              id_late, open_late;

    assign sq     = i_in.squelch_open;
    assign tone   = i_in.tone_present;
    assign accept = i_in.valid && i_in.ready;
    assign pop    = r_out_v && o_out.ready;

    assign i_in.ready             = !r_skd_v;
    assign o_out.valid            = r_out_v;
    assign o_out.tx_on            = r_out.tx_on;
    assign o_out.sound_code       = r_out.sound_code;
    assign o_out.id_before_sound  = r_out.id_before_sound;
    assign o_out.announce_request = r_out.announce_request;
    assign o_out.session_end      = r_out.session_end;
    assign o_out.session_ms       = r_out.session_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_to   <= RST_TAIL_TIMEOUT;
            r_id_period <= RST_ID_PERIOD;
            r_max_talk  <= RST_MAX_TALK;
            r_min_tone  <= RST_MIN_TONE;
            r_tone_to   <= RST_TONE_TIMEOUT;
            r_tone_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAIL_TIMEOUT: r_tail_to   <= i_cfg_data;
                CFG_ID_PERIOD:    r_id_period <= i_cfg_data;
                CFG_MAX_TALK:     r_max_talk  <= i_cfg_data;
                CFG_MIN_TONE:     r_min_tone  <= i_cfg_data[TONE_W-1:0];
                CFG_TONE_TIMEOUT: r_tone_to   <= i_cfg_data;
                CFG_TONE_ENABLE:  r_tone_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign now1       = r_now + 1'b1;
    assign changed    = (sq != r_prev_sq) || (tone != r_prev_tone);
    assign elapsed    = (&r_phase) ? r_phase : r_phase + 1'b1;
    assign diff_ident = now1 - r_last;
    assign diff_open  = now1 - r_open;
    assign id_late    = diff_ident > {{(TIME_W-CFG_W){1'b0}}, r_id_period};
    assign open_late  = diff_open > {{(TIME_W-CFG_W){1'b0}}, r_id_period};

    always_comb begin
        timed   = 1'b1;
        lim_sel = r_max_talk;
        case (r_mode)
            MODE_TONEMEAS: lim_sel = r_tone_to;
            MODE_TALK:     lim_sel = r_max_talk;
            MODE_TAIL:     lim_sel = r_tail_to;
            default:       timed   = 1'b0;
        endcase
        limit = (lim_sel == '0) ? TIME_W'(1) : {{(TIME_W-CFG_W){1'b0}}, lim_sel};
    end

    always_comb begin
        n_mode  = r_mode;
        n_last  = r_last;
        n_open  = r_open;
        n_phase = elapsed;
        n_res   = '0;
        if (changed) begin
            n_phase = '0;
            case (r_mode)
                MODE_TONEWAIT: begin
                    n_mode = (sq && tone) ? MODE_TONEMEAS : MODE_IDLE;
                end
                MODE_TONEMEAS: begin
                    if (elapsed > {{(TIME_W-TONE_W){1'b0}}, r_min_tone}) begin
                        n_open           = now1;
                        n_mode           = MODE_TALK;
                        n_res.sound_code = SND_CANCEL;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_TALK: begin
                    if (!sq) begin
                        n_mode = MODE_TAIL;
                        if (r_last == '0) begin
                            n_last           = TIME_W'(1);
                            n_res.sound_code = SND_STARTUP;
                        end else if (id_late) begin
                            n_last           = now1;
                            n_res.sound_code = SND_IDENT;
                        end else begin
                            n_res.sound_code = SND_COURTESY;
                        end
                    end
                end
                default: begin
                    if (sq) begin
                        if (r_last != '0) begin
                            n_mode           = MODE_TALK;
                            n_res.sound_code = SND_CANCEL;
                        end else if (r_tone_en) begin
                            n_mode = tone ? MODE_TONEMEAS : MODE_TONEWAIT;
                        end else begin
                            n_last           = TIME_W'(1);
                            n_open           = now1;
                            n_mode           = MODE_TALK;
                            n_res.sound_code = SND_CANCEL;
                        end
                    end else if (r_mode != MODE_TAIL) begin
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end else if (timed && (elapsed >= limit)) begin
            n_phase = '0;
            if (r_mode == MODE_TONEMEAS) begin
                n_mode = MODE_IDLE;
            end else begin
                n_res.session_end = 1'b1;
                n_res.session_ms  = diff_open;
                n_last            = '0;
                n_mode            = MODE_IDLE;
                if (r_mode == MODE_TALK) begin
                    n_res.id_before_sound = id_late;
                    n_res.sound_code      = SND_LONG;
                end else if (r_last <= TIME_W'(1)) begin
                    n_res.sound_code = SND_INACTIVE;
                end else begin
                    n_res.announce_request = open_late;
                    n_res.sound_code       = SND_SIGNOFF;
                end
            end
        end
        n_res.tx_on = (n_mode == MODE_TALK) || (n_mode == MODE_TAIL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_now       <= '0;
            r_last      <= '0;
            r_open      <= '0;
            r_phase     <= '0;
            r_prev_sq   <= 1'b0;
            r_prev_tone <= 1'b0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_now       <= now1;
            r_last      <= n_last;
            r_open      <= n_open;
            r_phase     <= n_phase;
            r_prev_sq   <= sq;
            r_prev_tone <= tone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (pop) begin
                r_out   <= r_skd;
                r_skd_v <= 1'b0;
            end
        end else if (!r_out_v || pop) begin
            r_out_v <= accept;
            if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skd   <= n_res;
            r_skd_v <= 1'b1;
        end
    end

    a_skd_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_v |-> r_out_v) else $error("skid entry held without an output entry");

    a_skd_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_v && pop) |=> (r_out == $past(r_skd)))
        else $error("skid entry lost when output was taken");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_out_v) |=> r_out_v) else $error("accepted item produced no result");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_res.session_end) |=> (r_mode == MODE_IDLE && r_last == '0))
        else $error("session closed but controller not idle");

endmodule
`default_nettype wire
